// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SHORT_TIME    = 3'd0,
        CFG_HOLD_TIME     = 3'd1,
        CFG_LONG_TIME     = 3'd2,
        CFG_SLOW_INTERVAL = 3'd3,
        CFG_FAST_INTERVAL = 3'd4,
        CFG_SLOW_REPEATS  = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [15:0] RstShortTime    = 16'd10;
    localparam logic [15:0] RstHoldTime     = 16'd100;
    localparam logic [15:0] RstLongTime     = 16'd1000;
    localparam logic [15:0] RstSlowInterval = 16'd300;
    localparam logic [15:0] RstFastInterval = 16'd120;
    localparam logic [7:0]  RstSlowRepeats  = 8'd6;

    typedef struct packed {
        logic [15:0] short_time;
        logic [15:0] hold_time;
        logic [15:0] long_time;
        logic [15:0] slow_interval;
        logic [15:0] fast_interval;
        logic [7:0]  slow_repeats;
    } t_cfg;

    // Per-button tracking state
    typedef struct packed {
        logic        last_level;
        logic [31:0] press_start;
        logic        short_flag;
        logic        repeat_flag;
        logic        long_flag;
        logic [15:0] poll_count;
        logic [7:0]  repeats_done;
    } t_state;

    // One poll
    typedef struct packed {
        logic        pin_level;
        logic [31:0] now;
        logic        ack_short;
        logic        ack_repeat;
        logic        ack_long;
    } t_poll;

    // One result word
    typedef struct packed {
        logic short_event;
        logic repeat_event;
        logic long_event;
        logic held;
    } t_result;

endpackage

// ===== hw/rtl/bpc_eval.sv =====
module bpc_eval
    import bpc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_poll   i_poll,
    output t_state  o_state,
    output t_result o_result
);

    logic        rise;
    logic [31:0] start;
    logic [31:0] elapsed;
    logic [15:0] pc_inc;
    t_state      upd;

    // Press start and elapsed time, modulo 2^32
    assign rise    = i_poll.pin_level & ~i_state.last_level;
    assign start   = rise ? i_poll.now : i_state.press_start;
    assign elapsed = i_poll.now - start;
    assign pc_inc  = i_state.poll_count + 16'd1;

    // Flag and counter update for this poll
    always_comb begin
        upd             = i_state;
        upd.press_start = start;
        upd.last_level  = i_poll.pin_level;

        if (i_poll.pin_level && elapsed == {16'd0, i_cfg.short_time}) begin
            upd.short_flag = 1'b1;
        end

        if (i_poll.pin_level && elapsed > {16'd0, i_cfg.hold_time}) begin
            upd.poll_count = pc_inc;
            if (i_state.repeats_done < i_cfg.slow_repeats) begin
                if (pc_inc == i_cfg.slow_interval) begin
                    upd.repeat_flag  = 1'b1;
                    upd.poll_count   = '0;
                    upd.repeats_done = i_state.repeats_done + 8'd1;
                end
            end else if (pc_inc == i_cfg.fast_interval) begin
                upd.repeat_flag = 1'b1;
                upd.poll_count  = '0;
            end
        end else begin
            upd.poll_count   = '0;
            upd.repeats_done = '0;
            upd.repeat_flag  = 1'b0;
        end

        if (i_poll.pin_level && elapsed == {16'd0, i_cfg.long_time}) begin
            upd.long_flag = 1'b1;
        end
    end

    // Report flags before the acks clear them
    always_comb begin
        o_result.short_event  = upd.short_flag;
        o_result.repeat_event = upd.repeat_flag;
        o_result.long_event   = upd.long_flag;
        o_result.held         = i_poll.pin_level;

        o_state = upd;
        if (i_poll.ack_short) begin
            o_state.short_flag = 1'b0;
        end
        if (i_poll.ack_repeat) begin
            o_state.repeat_flag = 1'b0;
        end
        if (i_poll.ack_long) begin
            o_state.long_flag = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/button_press_classifier.sv =====
// Button press classifier: short press, long press and auto-repeat for one
// button, one poll per input word.
// Input channel: i_valid / o_stall with fields pin_level, now and three ack
// bits. Output channel: o_valid / i_stall carrying the event flags after the
// poll's update plus the sampled level. Config: i_cfg_valid / o_cfg_ready with
// a register index and 16-bit data (slow_repeats uses the low 8 bits).
// Pipeline: the poll register captures an accepted poll, the evaluation works
// on it combinationally and the result register captures its result word.
// Throughput: one poll per cycle while the receiver does not stall; the
// evaluation is a 32-bit subtract, a few compares and a 16-bit counter
// increment between the poll register and the result register.
// Reset (synchronous, active low) restores register defaults, clears all
// flags, counters and the press start, and empties both stages.
// When the receiver stalls, the result register holds; a pending poll then
// stalls the input side until the result is taken.
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // poll channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pin_level,
    input  logic [31:0]         i_now,
    input  logic                i_ack_short,
    input  logic                i_ack_repeat,
    input  logic                i_ack_long,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_short_event,
    output logic                o_repeat_event,
    output logic                o_long_event,
    output logic                o_held,
    // configuration write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_st;
    t_state  n_st;
    t_poll   r_poll;
    logic    r_in_valid;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    out_free;
    logic    eval_go;
    logic    in_go;

    // Handshake control
    assign out_free    = ~r_out_valid | ~i_stall;
    assign eval_go     = r_in_valid & out_free;
    assign o_stall     = r_in_valid & ~out_free;
    assign in_go       = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_time    <= RstShortTime;
            r_cfg.hold_time     <= RstHoldTime;
            r_cfg.long_time     <= RstLongTime;
            r_cfg.slow_interval <= RstSlowInterval;
            r_cfg.fast_interval <= RstFastInterval;
            r_cfg.slow_repeats  <= RstSlowRepeats;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_TIME:    r_cfg.short_time    <= i_cfg_data;
                CFG_HOLD_TIME:     r_cfg.hold_time     <= i_cfg_data;
                CFG_LONG_TIME:     r_cfg.long_time     <= i_cfg_data;
                CFG_SLOW_INTERVAL: r_cfg.slow_interval <= i_cfg_data;
                CFG_FAST_INTERVAL: r_cfg.fast_interval <= i_cfg_data;
                CFG_SLOW_REPEATS:  r_cfg.slow_repeats  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Poll register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_go) begin
            r_in_valid <= 1'b1;
        end else if (eval_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_poll.pin_level  <= i_pin_level;
            r_poll.now        <= i_now;
            r_poll.ack_short  <= i_ack_short;
            r_poll.ack_repeat <= i_ack_repeat;
            r_poll.ack_long   <= i_ack_long;
        end
    end

    // Evaluation of one poll
    bpc_eval u_eval (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_poll   (r_poll),
        .o_state  (n_st),
        .o_result (n_res)
    );

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (eval_go) begin
            r_st <= n_st;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_short_event  = r_res.short_event;
    assign o_repeat_event = r_res.repeat_event;
    assign o_long_event   = r_res.long_event;
    assign o_held         = r_res.held;

`ifndef NO_ASSERTIONS
    // Repeat flag only survives while the button stays down
    a_repeat_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.repeat_flag |-> r_st.last_level)
        else $error("repeat flag set with button released");

    // A reported repeat always comes with the button held
    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_repeat_event) |-> o_held)
        else $error("repeat event without held level");

    // Rising edge captures the poll time as press start
    a_press_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eval_go && r_poll.pin_level && !r_st.last_level)
        |=> (r_st.press_start == $past(r_poll.now)))
        else $error("press start not captured on rising edge");

    // Input side only stalls behind an occupied result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && r_in_valid))
        else $error("input stalled with free result register");
`endif

endmodule
